### hw/rtl/nsa_pkg.sv
package nsa_pkg;

    localparam int SLOTS = 12;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int FREQ_W = 19;
    localparam int HALF_W = 11;
    localparam int TIME_W = 32;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 20;

    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
    localparam logic [HALF_W-1:0] HALF_MAX = '1;

    // Register reset values.
    localparam logic [11:0] RST_MATCH_WIDTH = 12'd480;
    localparam logic [15:0] RST_SETTLE_TIME = 16'd700;
    localparam logic [19:0] RST_HOLD_TIME = 20'd60000;
    localparam logic [HALF_W-1:0] RST_BASE_HALF = 11'd480;
    localparam logic [HALF_W-1:0] RST_WIDEN_STEP = 11'd240;
    localparam logic [HALF_W-1:0] RST_MAX_HALF = 11'd1200;
    localparam logic [FREQ_W-1:0] RST_PARK_LOW = 19'd376000;
    localparam logic [FREQ_W-1:0] RST_PARK_HIGH = 19'd382400;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_WIDTH = 4'd0,
        CFG_SETTLE_TIME = 4'd1,
        CFG_HOLD_TIME   = 4'd2,
        CFG_BASE_HALF   = 4'd3,
        CFG_WIDEN_STEP  = 4'd4,
        CFG_MAX_HALF    = 4'd5,
        CFG_PARK_LOW    = 4'd6,
        CFG_PARK_HIGH   = 4'd7
    } t_cfg_reg;

    typedef enum logic {
        REQ_TONE = 1'b0,
        REQ_POLL = 1'b1
    } t_req;

    typedef struct packed {
        logic [11:0]       match_width;
        logic [15:0]       settle_time;
        logic [19:0]       hold_time;
        logic [HALF_W-1:0] base_half_width;
        logic [HALF_W-1:0] widen_step;
        logic [HALF_W-1:0] max_half_width;
        logic [FREQ_W-1:0] park_low;
        logic [FREQ_W-1:0] park_high;
    } t_cfg;

    typedef struct packed {
        logic              req_type;
        logic [FREQ_W-1:0] tone_freq;
        logic [TIME_W-1:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [3:0]        slot_index;
        logic [FREQ_W-1:0] lower_edge;
        logic [FREQ_W-1:0] upper_edge;
        logic              parked;
        logic              last;
    } t_out;

    typedef struct packed {
        logic              active;
        logic [FREQ_W-1:0] freq;
        logic [HALF_W-1:0] half;
        logic [TIME_W-1:0] set_time;
        logic [TIME_W-1:0] seen_time;
    } t_slot;

    typedef struct packed {
        logic              seen_en;
        logic              full_en;
        logic              clr_en;
        logic [IDX_W-1:0]  idx;
        logic [FREQ_W-1:0] freq;
        logic [HALF_W-1:0] half;
        logic [TIME_W-1:0] stamp;
    } t_tbl_wr;

endpackage

### hw/rtl/nsa_alu.sv
module nsa_alu (
    input  logic [nsa_pkg::TIME_W-1:0] i_a,
    input  logic [nsa_pkg::TIME_W-1:0] i_b,
    output logic [nsa_pkg::TIME_W-1:0] o_diff,
    output logic [nsa_pkg::TIME_W-1:0] o_adiff,
    output logic                       o_lt
);

    logic [nsa_pkg::TIME_W:0] ab;
    logic [nsa_pkg::TIME_W:0] ba;

    assign ab = {1'b0, i_a} - {1'b0, i_b};
    assign ba = {1'b0, i_b} - {1'b0, i_a};

    assign o_lt = ab[nsa_pkg::TIME_W];
    assign o_diff = ab[nsa_pkg::TIME_W-1:0];
    assign o_adiff = o_lt ? ba[nsa_pkg::TIME_W-1:0] : ab[nsa_pkg::TIME_W-1:0];

endmodule

### hw/rtl/nsa_table.sv
module nsa_table (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [nsa_pkg::IDX_W-1:0] i_rd_idx,
    output nsa_pkg::t_slot            o_rd,
    input  nsa_pkg::t_tbl_wr          i_wr
);

    logic [nsa_pkg::SLOTS-1:0]  r_active;
    logic [nsa_pkg::FREQ_W-1:0] r_freq [nsa_pkg::SLOTS];
    logic [nsa_pkg::HALF_W-1:0] r_half [nsa_pkg::SLOTS];
    logic [nsa_pkg::TIME_W-1:0] r_set  [nsa_pkg::SLOTS];
    logic [nsa_pkg::TIME_W-1:0] r_seen [nsa_pkg::SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_wr.full_en) begin
            r_active[i_wr.idx] <= 1'b1;
        end else if (i_wr.clr_en) begin
            r_active[i_wr.idx] <= 1'b0;
        end
    end

    // Frequency, width and times are only read for active slots.
    always_ff @(posedge i_clk) begin
        if (i_wr.full_en) begin
            r_freq[i_wr.idx] <= i_wr.freq;
            r_half[i_wr.idx] <= i_wr.half;
            r_set[i_wr.idx]  <= i_wr.stamp;
            r_seen[i_wr.idx] <= i_wr.stamp;
        end else if (i_wr.seen_en) begin
            r_seen[i_wr.idx] <= i_wr.stamp;
        end
    end

    always_comb begin
        o_rd.active    = r_active[i_rd_idx];
        o_rd.freq      = r_freq[i_rd_idx];
        o_rd.half      = r_half[i_rd_idx];
        o_rd.set_time  = r_set[i_rd_idx];
        o_rd.seen_time = r_seen[i_rd_idx];
    end

endmodule

### hw/rtl/nsa_seq.sv
module nsa_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  nsa_pkg::t_cfg             i_cfg,
    input  logic                      i_in_valid,
    input  nsa_pkg::t_in              i_in_data,
    output logic                      o_busy,
    input  nsa_pkg::t_slot            i_slot,
    output logic [nsa_pkg::IDX_W-1:0] o_rd_idx,
    output nsa_pkg::t_tbl_wr          o_wr,
    output logic                      o_emit_valid,
    output nsa_pkg::t_out             o_emit,
    input  logic                      i_emit_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_SETTLE,
        S_STEAL,
        S_ENGAGE,
        S_POLL,
        S_POLL_END
    } t_state;

    localparam logic [nsa_pkg::IDX_W-1:0] LAST_IDX = nsa_pkg::IDX_W'(nsa_pkg::SLOTS - 1);
    localparam logic [nsa_pkg::IDX_W-1:0] ONE_IDX = nsa_pkg::IDX_W'(1);

    t_state                     r_state, n_state;
    logic [nsa_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic [nsa_pkg::FREQ_W-1:0] r_tone, n_tone;
    logic [nsa_pkg::TIME_W-1:0] r_now, n_now;
    logic                       r_free_vld, n_free_vld;
    logic [nsa_pkg::IDX_W-1:0]  r_free_idx, n_free_idx;
    logic [nsa_pkg::TIME_W-1:0] r_best, n_best;
    logic [nsa_pkg::IDX_W-1:0]  r_old_idx, n_old_idx;
    logic [nsa_pkg::IDX_W-1:0]  r_tgt_idx, n_tgt_idx;
    logic [nsa_pkg::FREQ_W-1:0] r_tgt_freq, n_tgt_freq;
    logic [nsa_pkg::HALF_W-1:0] r_tgt_half, n_tgt_half;
    logic                       r_pend_vld, n_pend_vld;
    logic [nsa_pkg::IDX_W-1:0]  r_pend_idx, n_pend_idx;

    logic [nsa_pkg::TIME_W-1:0] alu_a, alu_b, alu_diff, alu_adiff;
    logic                       alu_lt;
    logic                       is_last;
    logic                       matched, park;
    logic [nsa_pkg::HALF_W:0]   half_sum;
    logic [nsa_pkg::HALF_W-1:0] new_half;
    logic [nsa_pkg::FREQ_W:0]   up_sum;
    logic [nsa_pkg::FREQ_W-1:0] lo_edge, hi_edge;
    logic [nsa_pkg::IDX_W-1:0]  steal_idx;

    nsa_alu u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_diff  (alu_diff),
        .o_adiff (alu_adiff),
        .o_lt    (alu_lt)
    );

    // The single subtractor is steered by the state.
    always_comb begin
        alu_a = '0;
        alu_b = '0;
        unique case (r_state)
            S_MATCH: begin
                alu_a = nsa_pkg::TIME_W'(i_slot.freq);
                alu_b = nsa_pkg::TIME_W'(r_tone);
            end
            S_SETTLE: begin
                alu_a = r_now;
                alu_b = i_slot.set_time;
            end
            S_STEAL, S_POLL: begin
                alu_a = r_now;
                alu_b = i_slot.seen_time;
            end
            S_ENGAGE: begin
                alu_a = nsa_pkg::TIME_W'(r_tgt_freq);
                alu_b = nsa_pkg::TIME_W'(r_tgt_half);
            end
            S_IDLE, S_POLL_END: begin
                alu_a = '0;
                alu_b = '0;
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    assign is_last = (r_idx == LAST_IDX);
    assign matched = i_slot.active
        && (alu_adiff <= nsa_pkg::TIME_W'(i_cfg.match_width));
    assign park = i_slot.active && !(alu_diff < nsa_pkg::TIME_W'(i_cfg.hold_time));

    assign half_sum = {1'b0, i_slot.half} + {1'b0, i_cfg.widen_step};
    assign new_half = half_sum[nsa_pkg::HALF_W] ? nsa_pkg::HALF_MAX
                                                : half_sum[nsa_pkg::HALF_W-1:0];

    assign lo_edge = alu_lt ? '0 : alu_diff[nsa_pkg::FREQ_W-1:0];
    assign up_sum = {1'b0, r_tgt_freq} + (nsa_pkg::FREQ_W + 1)'(r_tgt_half);
    assign hi_edge = up_sum[nsa_pkg::FREQ_W] ? nsa_pkg::FREQ_MAX
                                             : up_sum[nsa_pkg::FREQ_W-1:0];

    // Oldest so far, including the slot read this cycle; ties keep the lower index.
    assign steal_idx = ((r_idx == '0) || (alu_diff > r_best)) ? r_idx : r_old_idx;

    assign o_busy = (r_state != S_IDLE);
    assign o_rd_idx = r_idx;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_tone     = r_tone;
        n_now      = r_now;
        n_free_vld = r_free_vld;
        n_free_idx = r_free_idx;
        n_best     = r_best;
        n_old_idx  = r_old_idx;
        n_tgt_idx  = r_tgt_idx;
        n_tgt_freq = r_tgt_freq;
        n_tgt_half = r_tgt_half;
        n_pend_vld = r_pend_vld;
        n_pend_idx = r_pend_idx;

        o_wr         = '0;
        o_wr.idx     = r_idx;
        o_wr.stamp   = r_now;
        o_emit_valid = 1'b0;
        o_emit       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_tone     = i_in_data.tone_freq;
                    n_now      = i_in_data.now_ms;
                    n_idx      = '0;
                    n_free_vld = 1'b0;
                    n_pend_vld = 1'b0;
                    n_state    = (i_in_data.req_type == nsa_pkg::REQ_POLL) ? S_POLL : S_MATCH;
                end
            end

            S_MATCH: begin
                if (matched) begin
                    o_wr.seen_en = 1'b1;
                    n_state      = S_SETTLE;
                end else begin
                    if (!i_slot.active && !r_free_vld) begin
                        n_free_vld = 1'b1;
                        n_free_idx = r_idx;
                    end
                    if (is_last) begin
                        n_tgt_freq = r_tone;
                        n_tgt_half = i_cfg.base_half_width;
                        if (r_free_vld || !i_slot.active) begin
                            n_tgt_idx = r_free_vld ? r_free_idx : r_idx;
                            n_state   = S_ENGAGE;
                        end else begin
                            n_idx   = '0;
                            n_state = S_STEAL;
                        end
                    end else begin
                        n_idx = r_idx + ONE_IDX;
                    end
                end
            end

            S_SETTLE: begin
                if (alu_diff < nsa_pkg::TIME_W'(i_cfg.settle_time)
                    || i_slot.half >= i_cfg.max_half_width) begin
                    n_state = S_IDLE;
                end else begin
                    n_tgt_idx  = r_idx;
                    n_tgt_freq = i_slot.freq;
                    n_tgt_half = new_half;
                    n_state    = S_ENGAGE;
                end
            end

            S_STEAL: begin
                n_old_idx = steal_idx;
                if (steal_idx == r_idx) begin
                    n_best = alu_diff;
                end
                if (is_last) begin
                    n_tgt_idx = steal_idx;
                    n_state   = S_ENGAGE;
                end else begin
                    n_idx = r_idx + ONE_IDX;
                end
            end

            S_ENGAGE: begin
                o_emit_valid      = 1'b1;
                o_emit.slot_index = 4'(r_tgt_idx);
                o_emit.lower_edge = lo_edge;
                o_emit.upper_edge = hi_edge;
                o_emit.parked     = 1'b0;
                o_emit.last       = 1'b1;
                if (i_emit_ready) begin
                    o_wr.full_en = 1'b1;
                    o_wr.idx     = r_tgt_idx;
                    o_wr.freq    = r_tgt_freq;
                    o_wr.half    = r_tgt_half;
                    n_state      = S_IDLE;
                end
            end

            S_POLL: begin
                // A parked slot is held back one step so that the final
                // item of the scan can carry the last flag.
                o_emit.slot_index = 4'(r_pend_idx);
                o_emit.lower_edge = i_cfg.park_low;
                o_emit.upper_edge = i_cfg.park_high;
                o_emit.parked     = 1'b1;
                o_emit.last       = 1'b0;
                if (!(park && r_pend_vld && !i_emit_ready)) begin
                    if (park) begin
                        o_emit_valid = r_pend_vld;
                        o_wr.clr_en  = 1'b1;
                        n_pend_vld   = 1'b1;
                        n_pend_idx   = r_idx;
                    end
                    if (is_last) begin
                        n_state = S_POLL_END;
                    end else begin
                        n_idx = r_idx + ONE_IDX;
                    end
                end
            end

            S_POLL_END: begin
                o_emit.slot_index = 4'(r_pend_idx);
                o_emit.lower_edge = i_cfg.park_low;
                o_emit.upper_edge = i_cfg.park_high;
                o_emit.parked     = 1'b1;
                o_emit.last       = 1'b1;
                o_emit_valid      = r_pend_vld;
                if (!r_pend_vld || i_emit_ready) begin
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_free_vld <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_free_vld <= n_free_vld;
            r_pend_vld <= n_pend_vld;
        end
        r_idx      <= n_idx;
        r_tone     <= n_tone;
        r_now      <= n_now;
        r_free_idx <= n_free_idx;
        r_best     <= n_best;
        r_old_idx  <= n_old_idx;
        r_tgt_idx  <= n_tgt_idx;
        r_tgt_freq <= n_tgt_freq;
        r_tgt_half <= n_tgt_half;
        r_pend_idx <= n_pend_idx;
    end

endmodule

### hw/rtl/notch_slot_allocator.sv
// Notch slot allocator: keeps a table of band-reject notch slots and turns
// tone reports and poll ticks into slot retune commands.
// Input channel (i_in_valid / o_in_stall, payload i_in_data): one item is a
// tone report or a poll tick. Output channel (o_out_valid / i_out_stall,
// payload o_out_data): each item is one slot command; the last flag marks
// the final command caused by an input item. A tone report gives zero or
// one command, a poll tick zero up to one per slot.
// Configuration (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data) is
// always ready and is to be written while the block is idle.
// A tone report scans the slots one per cycle through one shared
// subtractor. o_in_stall stays high for the match scan up to slot k and a
// settle check when slot k matches, plus an engage step when it is widened;
// for the full match scan and an engage step when a free slot is taken; and
// for the match scan, a steal scan and an engage step when the oldest slot
// is taken. A poll tick runs a poll scan and an end step. Output stalls add
// to these. Each command is registered and leaves from the output register.
// Reset clears all slots to inactive and loads the register defaults.
// While the receiver stalls, the output register holds its command and the
// scan waits at the next command.
module notch_slot_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  nsa_pkg::t_in                      i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output nsa_pkg::t_out                     o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [nsa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [nsa_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    nsa_pkg::t_cfg              r_cfg;
    nsa_pkg::t_out              r_out;
    logic                       r_out_vld;
    logic                       busy;
    nsa_pkg::t_slot             slot_rd;
    logic [nsa_pkg::IDX_W-1:0]  rd_idx;
    nsa_pkg::t_tbl_wr           tbl_wr;
    logic                       emit_valid;
    logic                       emit_ready;
    nsa_pkg::t_out              emit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.match_width     <= nsa_pkg::RST_MATCH_WIDTH;
            r_cfg.settle_time     <= nsa_pkg::RST_SETTLE_TIME;
            r_cfg.hold_time       <= nsa_pkg::RST_HOLD_TIME;
            r_cfg.base_half_width <= nsa_pkg::RST_BASE_HALF;
            r_cfg.widen_step      <= nsa_pkg::RST_WIDEN_STEP;
            r_cfg.max_half_width  <= nsa_pkg::RST_MAX_HALF;
            r_cfg.park_low        <= nsa_pkg::RST_PARK_LOW;
            r_cfg.park_high       <= nsa_pkg::RST_PARK_HIGH;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nsa_pkg::CFG_MATCH_WIDTH: r_cfg.match_width     <= i_cfg_data[11:0];
                nsa_pkg::CFG_SETTLE_TIME: r_cfg.settle_time     <= i_cfg_data[15:0];
                nsa_pkg::CFG_HOLD_TIME:   r_cfg.hold_time       <= i_cfg_data[19:0];
                nsa_pkg::CFG_BASE_HALF:   r_cfg.base_half_width <= i_cfg_data[10:0];
                nsa_pkg::CFG_WIDEN_STEP:  r_cfg.widen_step      <= i_cfg_data[10:0];
                nsa_pkg::CFG_MAX_HALF:    r_cfg.max_half_width  <= i_cfg_data[10:0];
                nsa_pkg::CFG_PARK_LOW:    r_cfg.park_low        <= i_cfg_data[18:0];
                nsa_pkg::CFG_PARK_HIGH:   r_cfg.park_high       <= i_cfg_data[18:0];
                default: begin
                end
            endcase
        end
    end

    nsa_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (rd_idx),
        .o_rd     (slot_rd),
        .i_wr     (tbl_wr)
    );

    nsa_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_busy       (busy),
        .i_slot       (slot_rd),
        .o_rd_idx     (rd_idx),
        .o_wr         (tbl_wr),
        .o_emit_valid (emit_valid),
        .o_emit       (emit),
        .i_emit_ready (emit_ready)
    );

    assign o_in_stall = busy;

    // Output register: takes a new item when empty or when its item leaves.
    assign emit_ready = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit_valid && emit_ready) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
        if (emit_valid && emit_ready) begin
            r_out <= emit;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
